// ----- src/bscm_pkg.sv -----
// Shared constants for the bounding box scale, crop and map block.
// Used by the divider cells, the divider chain, the top level and the checker.
package bscm_pkg;

    localparam int COORD_BITS_DEF = 13;
    localparam int BOX_LANES      = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int MIN_SIDE       = 2;
    localparam int SMALL_START    = -2;

    localparam logic [CFG_IDX_W-1:0] REG_DETECT_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_SIZE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SIZE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CROP_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CROP_ORIGIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CROP_EXTENT = 3'd5;

endpackage

// ----- src/bscm_div_cell.sv -----
// One cell of the pipelined restoring divider: one quotient bit for each lane.
// Depends on bscm_pkg for the lane count.
module bscm_div_cell
    import bscm_pkg::*;
#(
    parameter int W     = 2 * COORD_BITS_DEF,
    parameter int DW    = COORD_BITS_DEF,
    parameter int TAG_W = 1
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic                            in_valid,
    input  logic [TAG_W-1:0]                in_tag,
    input  logic [BOX_LANES-1:0][DW-1:0]    in_rem,
    input  logic [BOX_LANES-1:0][W-1:0]     in_dq,
    input  logic [BOX_LANES-1:0][DW-1:0]    divisor,
    output logic                            out_valid,
    output logic [TAG_W-1:0]                out_tag,
    output logic [BOX_LANES-1:0][DW-1:0]    out_rem,
    output logic [BOX_LANES-1:0][W-1:0]     out_dq
);

    logic                         valid_reg;
    logic [TAG_W-1:0]             tag_reg;
    logic [BOX_LANES-1:0][DW-1:0] rem_reg, rem_next;
    logic [BOX_LANES-1:0][W-1:0]  dq_reg, dq_next;

    // The dividend shifts out at the top while quotient bits fill in at the bottom.
    always_comb
    begin
        logic [DW:0] trial;
        logic        ge;
        for (int i = 0; i < BOX_LANES; i++)
        begin
            trial       = {in_rem[i], in_dq[i][W-1]};
            ge          = trial >= {1'b0, divisor[i]};
            rem_next[i] = ge ? DW'(trial - {1'b0, divisor[i]}) : trial[DW-1:0];
            dq_next[i]  = {in_dq[i][W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tag_reg <= in_tag;
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_tag   = tag_reg;
    assign out_rem   = rem_reg;
    assign out_dq    = dq_reg;

endmodule

// ----- src/bscm_div_chain.sv -----
// Row of W divider cells that divides four lanes by their divisors at full rate while advance is high.
// Depends on bscm_pkg and bscm_div_cell.
module bscm_div_chain
    import bscm_pkg::*;
#(
    parameter int W     = 2 * COORD_BITS_DEF,
    parameter int DW    = COORD_BITS_DEF,
    parameter int TAG_W = 1
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic                            in_valid,
    input  logic [TAG_W-1:0]                in_tag,
    input  logic [BOX_LANES-1:0][W-1:0]     dividend,
    input  logic [BOX_LANES-1:0][DW-1:0]    divisor,
    output logic                            out_valid,
    output logic [TAG_W-1:0]                out_tag,
    output logic [BOX_LANES-1:0][W-1:0]     quotient
);

    logic [W:0]                           stage_valid;
    logic [W:0][TAG_W-1:0]                stage_tag;
    logic [W:0][BOX_LANES-1:0][DW-1:0]    stage_rem;
    logic [W:0][BOX_LANES-1:0][W-1:0]     stage_dq;

    assign stage_valid[0] = in_valid;
    assign stage_tag[0]   = in_tag;
    assign stage_rem[0]   = '0;
    assign stage_dq[0]    = dividend;

    for (genvar k = 0; k < W; k++)
    begin : g_cell
        bscm_div_cell #(.W(W), .DW(DW), .TAG_W(TAG_W)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (stage_valid[k]),
            .in_tag    (stage_tag[k]),
            .in_rem    (stage_rem[k]),
            .in_dq     (stage_dq[k]),
            .divisor   (divisor),
            .out_valid (stage_valid[k+1]),
            .out_tag   (stage_tag[k+1]),
            .out_rem   (stage_rem[k+1]),
            .out_dq    (stage_dq[k+1])
        );
    end

    assign out_valid = stage_valid[W];
    assign out_tag   = stage_tag[W];
    assign quotient  = stage_dq[W];

endmodule

// ----- src/bbox_scale_crop_map_unit.sv -----
// Top level of the bounding box scale, crop and map block.
// Depends on bscm_pkg and bscm_div_chain.
//
// A detection box enters on the s_ stream as four corner coordinates and leaves on
// the m_ stream as a visible flag with the overlay start, width and height. Each
// corner is scaled to the source frame, clipped to the crop window, rebased and
// scaled to the encoder output size.
// The configuration registers are written through cfg_we, cfg_index and cfg_data;
// the user must write them only while no request is in flight, as the block itself does not enforce this.
// One request is accepted every cycle while the output is not stalled. A request passes the
// first multiply register, a chain of 2*COORD_BITS divider cells (one per quotient bit), the
// clip register, the second multiply register, a second such chain and the output register.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_tready drops in the same cycle; no request is lost or repeated.
// Reset clears the configuration registers and the valid flags and empties the pipeline; with all sizes at
// zero every box gives an invisible, all-zero result.
module bbox_scale_crop_map_unit
    import bscm_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int P        = 2 * COORD_BITS,
    localparam int IN_W     = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W    = ((4 * COORD_BITS + 2 + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // box_left, box_top, box_right, box_bottom from the lowest bit up
    input  logic [IN_W-1:0]       s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // start_x, start_y, box_width, box_height from the lowest bit up
    output logic [OUT_W-1:0]      m_tdata,
    // visible
    output logic                  m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [P-1:0]          cfg_data
);

    localparam int C = COORD_BITS;
    localparam int S = COORD_BITS + 1;

    logic [P-1:0] detect_size_reg, source_size_reg, output_size_reg;
    logic [P-1:0] crop_origin_reg, crop_extent_reg;
    logic         crop_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detect_size_reg <= '0;
            source_size_reg <= '0;
            output_size_reg <= '0;
            crop_enable_reg <= 1'b0;
            crop_origin_reg <= '0;
            crop_extent_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DETECT_SIZE: detect_size_reg <= cfg_data;
                REG_SOURCE_SIZE: source_size_reg <= cfg_data;
                REG_OUTPUT_SIZE: output_size_reg <= cfg_data;
                REG_CROP_ENABLE: crop_enable_reg <= cfg_data[0];
                REG_CROP_ORIGIN: crop_origin_reg <= cfg_data;
                REG_CROP_EXTENT: crop_extent_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [C-1:0] dw, dh, sw, sh, ow, oh, cx, cy, cw, ch;
    logic         zero_size;

    always_comb
    begin
        dw = detect_size_reg[P-1:C];
        dh = detect_size_reg[C-1:0];
        sw = source_size_reg[P-1:C];
        sh = source_size_reg[C-1:0];
        ow = output_size_reg[P-1:C];
        oh = output_size_reg[C-1:0];
        cx = crop_enable_reg ? crop_origin_reg[P-1:C] : '0;
        cy = crop_enable_reg ? crop_origin_reg[C-1:0] : '0;
        cw = crop_enable_reg ? crop_extent_reg[P-1:C] : sw;
        ch = crop_enable_reg ? crop_extent_reg[C-1:0] : sh;
        zero_size = (dw == '0) || (dh == '0) || (sw == '0) || (sh == '0)
                 || (ow == '0) || (oh == '0) || (cw == '0) || (ch == '0);
    end

    // The whole pipeline moves whenever the output register is free or being taken.
    logic advance;
    logic m_tvalid_reg;
    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;

    // Lanes are left, top, right, bottom: even lanes are x, odd lanes are y.
    logic [BOX_LANES-1:0][C-1:0] src_div, out_div;
    always_comb
    begin
        for (int i = 0; i < BOX_LANES; i++)
        begin
            src_div[i] = (i % 2 == 0) ? dw : dh;
            out_div[i] = (i % 2 == 0) ? cw : ch;
        end
    end

    // Scale to the source frame: multiply here, divide in the first chain.
    logic                        mul1_valid_reg;
    logic [BOX_LANES-1:0][P-1:0] mul1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            mul1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < BOX_LANES; i++)
            begin
                mul1_reg[i] <= P'(s_tdata[i*C +: C]) * P'((i % 2 == 0) ? sw : sh);
            end
        end
    end

    logic                        div1_valid;
    logic                        div1_tag;
    logic [BOX_LANES-1:0][P-1:0] src_coord;

    bscm_div_chain #(.W(P), .DW(C), .TAG_W(1)) u_src_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (mul1_valid_reg),
        .in_tag    (1'b0),
        .dividend  (mul1_reg),
        .divisor   (src_div),
        .out_valid (div1_valid),
        .out_tag   (div1_tag),
        .quotient  (src_coord)
    );

    // Clip to the window and rebase. A non-empty box leaves every offset at or below the extent.
    logic                        clip_valid_reg;
    logic                        clip_empty_reg;
    logic [BOX_LANES-1:0][C-1:0] clip_reg;

    logic [P-1:0] x1c, y1c, x2c, y2c, x_lim, y_lim;
    logic         clip_empty;
    always_comb
    begin
        x_lim = P'(cx) + P'(cw);
        y_lim = P'(cy) + P'(ch);
        x1c = (src_coord[0] < P'(cx)) ? P'(cx) : src_coord[0];
        y1c = (src_coord[1] < P'(cy)) ? P'(cy) : src_coord[1];
        x2c = (src_coord[2] > x_lim) ? x_lim : src_coord[2];
        y2c = (src_coord[3] > y_lim) ? y_lim : src_coord[3];
        clip_empty = (x2c <= x1c) || (y2c <= y1c) || div1_tag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            clip_valid_reg <= div1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            clip_empty_reg <= clip_empty;
            clip_reg[0]    <= C'(x1c - P'(cx));
            clip_reg[1]    <= C'(y1c - P'(cy));
            clip_reg[2]    <= C'(x2c - P'(cx));
            clip_reg[3]    <= C'(y2c - P'(cy));
        end
    end

    logic                        mul2_valid_reg;
    logic                        mul2_empty_reg;
    logic [BOX_LANES-1:0][P-1:0] mul2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            mul2_valid_reg <= clip_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mul2_empty_reg <= clip_empty_reg;
            for (int i = 0; i < BOX_LANES; i++)
            begin
                mul2_reg[i] <= P'(clip_reg[i]) * P'((i % 2 == 0) ? ow : oh);
            end
        end
    end

    logic                        div2_valid;
    logic                        div2_empty;
    logic [BOX_LANES-1:0][P-1:0] out_coord;

    bscm_div_chain #(.W(P), .DW(C), .TAG_W(1)) u_out_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (mul2_valid_reg),
        .in_tag    (mul2_empty_reg),
        .dividend  (mul2_reg),
        .divisor   (out_div),
        .out_valid (div2_valid),
        .out_tag   (div2_empty),
        .quotient  (out_coord)
    );

    // The output quotients never exceed the output size, so the low bits hold them.
    logic [C-1:0] ox1, oy1, ox2, oy2, side_x, side_y;
    logic [C-1:0] width_next, height_next;
    logic [S-1:0] start_x_next, start_y_next;
    logic         visible_next;

    always_comb
    begin
        ox1 = out_coord[0][C-1:0];
        oy1 = out_coord[1][C-1:0];
        ox2 = out_coord[2][C-1:0];
        oy2 = out_coord[3][C-1:0];
        side_x = ox2 - ox1;
        side_y = oy2 - oy1;
        visible_next = !zero_size && !div2_empty && (ox2 > ox1) && (oy2 > oy1);
        width_next   = '0;
        height_next  = '0;
        start_x_next = '0;
        start_y_next = '0;
        if (visible_next)
        begin
            if (side_x <= C'(MIN_SIDE))
            begin
                width_next   = C'(MIN_SIDE);
                start_x_next = S'(SMALL_START);
            end
            else
            begin
                width_next   = side_x;
                start_x_next = {1'b0, ox1};
            end
            if (side_y <= C'(MIN_SIDE))
            begin
                height_next  = C'(MIN_SIDE);
                start_y_next = S'(SMALL_START);
            end
            else
            begin
                height_next  = side_y;
                start_y_next = {1'b0, oy1};
            end
        end
    end

    logic [OUT_W-1:0] m_tdata_reg;
    logic             m_tuser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_tvalid_reg <= div2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_tuser_reg <= visible_next;
            m_tdata_reg <= OUT_W'({height_next, width_next, start_y_next, start_x_next});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- src/bscm_checker.sv -----
// Port-level checks for the bounding box scale, crop and map block, bound to the top.
// Depends on bscm_pkg and bbox_scale_crop_map_unit.
module bscm_checker
    import bscm_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int OUT_W     = ((4 * COORD_BITS + 2 + 7) / 8) * 8
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tuser
);

    localparam int WB = 2 * (COORD_BITS + 1);
    localparam int HB = WB + COORD_BITS;

    // A waiting result stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled output must stop new requests.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request accepted while output stalled");

    // An invisible result carries no geometry.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("invisible result has nonzero fields");

    // A visible overlay is at least the minimum side in both directions.
    a_min: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[WB +: COORD_BITS] >= COORD_BITS'(MIN_SIDE))
            && (m_tdata[HB +: COORD_BITS] >= COORD_BITS'(MIN_SIDE)))
        else $error("visible overlay below minimum side");

    // With no result waiting the input is always open.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with free output");

endmodule

bind bbox_scale_crop_map_unit bscm_checker #(.COORD_BITS(COORD_BITS)) u_bscm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
